/* design/rme_pkg.sv */
`default_nettype none

package rme_pkg;

    localparam int VALUE_W    = 32;
    localparam int RESULT_W   = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CNT_W      = 5;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic [CFG_W-1:0] MODULUS_RST  = 32'd3233;
    localparam logic [CFG_W-1:0] PUB_EXP_RST  = 32'd7;
    localparam logic [CFG_W-1:0] PRIV_EXP_RST = 32'd1783;

    // last bit position of the value during reduction
    localparam logic [CNT_W-1:0] VALUE_LAST = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_RUN,
        ST_MUL_WB,
        ST_SQ_RUN,
        ST_SQ_WB,
        ST_FINISH
    } rme_state_t;

    typedef struct packed {
        logic load;
        logic red_step;
        logic mul_load;
        logic mul_sq;
        logic mul_step;
        logic acc_wr;
        logic base_wr;
        logic exp_shift;
        logic res_wr;
    } rme_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic exp_zero;
        logic exp_lsb;
        logic red_last;
        logic mul_last;
        logic out_full;
    } rme_status_t;

endpackage

`default_nettype wire

/* design/rme_ctrl.sv */
`default_nettype none

module rme_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  m_ready,
    input  rme_pkg::rme_status_t status,
    output rme_pkg::rme_cmd_t    cmd
);

    rme_pkg::rme_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rme_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rme_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.degenerate ? rme_pkg::ST_FINISH
                                                   : rme_pkg::ST_REDUCE;
                end
            end
            rme_pkg::ST_REDUCE: begin
                cmd.red_step = 1'b1;
                if (status.red_last) begin
                    state_next = rme_pkg::ST_CHECK;
                end
            end
            rme_pkg::ST_CHECK: begin
                priority if (status.exp_zero) begin
                    state_next = rme_pkg::ST_FINISH;
                end else if (status.exp_lsb) begin
                    cmd.mul_load = 1'b1;
                    state_next   = rme_pkg::ST_MUL_RUN;
                end else begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_sq   = 1'b1;
                    state_next   = rme_pkg::ST_SQ_RUN;
                end
            end
            rme_pkg::ST_MUL_RUN: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    state_next = rme_pkg::ST_MUL_WB;
                end
            end
            rme_pkg::ST_MUL_WB: begin
                // store acc and start squaring the base right away
                cmd.acc_wr   = 1'b1;
                cmd.mul_load = 1'b1;
                cmd.mul_sq   = 1'b1;
                state_next   = rme_pkg::ST_SQ_RUN;
            end
            rme_pkg::ST_SQ_RUN: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    state_next = rme_pkg::ST_SQ_WB;
                end
            end
            rme_pkg::ST_SQ_WB: begin
                cmd.base_wr   = 1'b1;
                cmd.exp_shift = 1'b1;
                state_next    = rme_pkg::ST_CHECK;
            end
            rme_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!status.out_full || m_ready) begin
                    cmd.res_wr = 1'b1;
                    state_next = rme_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rme_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/rme_dpath.sv */
`default_nettype none

module rme_dpath #(
    parameter int MOD_WIDTH = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [rme_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire  [rme_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire                              s_op,
    input  wire  [rme_pkg::VALUE_W-1:0]      s_value,
    input  wire                              m_ready,
    input  rme_pkg::rme_cmd_t                cmd,
    output rme_pkg::rme_status_t             status,
    output logic                             m_valid,
    output logic [rme_pkg::RESULT_W-1:0]     m_result
);

    localparam logic [rme_pkg::CNT_W-1:0] MUL_LAST = rme_pkg::CNT_W'(MOD_WIDTH - 1);

    logic [MOD_WIDTH-1:0]          cfg_mod_reg;
    logic [rme_pkg::CFG_W-1:0]     cfg_pub_reg;
    logic [rme_pkg::CFG_W-1:0]     cfg_priv_reg;
    logic                          res_valid_reg;

    logic                          op_reg;
    logic [rme_pkg::VALUE_W-1:0]   val_reg;
    logic [rme_pkg::CFG_W-1:0]     exp_reg;
    logic [MOD_WIDTH-1:0]          base_reg;
    logic [MOD_WIDTH-1:0]          acc_reg;
    logic [MOD_WIDTH-1:0]          mul_a_reg;
    logic [MOD_WIDTH-1:0]          mul_b_reg;
    logic [MOD_WIDTH-1:0]          prod_reg;
    logic [rme_pkg::CNT_W-1:0]     cnt_reg;
    logic [rme_pkg::RESULT_W-1:0]  res_reg;

    // shared doubling step: out = (2x + add) mod m, with x, add < m
    logic [MOD_WIDTH-1:0]          step_x;
    logic [MOD_WIDTH-1:0]          step_add;
    logic [MOD_WIDTH+1:0]          step_sum;
    logic [MOD_WIDTH+2:0]          step_d1;
    logic [MOD_WIDTH+2:0]          step_d2;
    logic [MOD_WIDTH-1:0]          step_out;

    always_comb begin
        step_x   = cmd.red_step ? base_reg : prod_reg;
        step_add = cmd.red_step ? {{(MOD_WIDTH-1){1'b0}}, val_reg[rme_pkg::VALUE_W-1]}
                                : (mul_b_reg[MOD_WIDTH-1] ? mul_a_reg : '0);
        step_sum = {1'b0, step_x, 1'b0} + {2'b00, step_add};
        step_d1  = {1'b0, step_sum} - {3'b000, cfg_mod_reg};
        step_d2  = {1'b0, step_sum} - {2'b00, cfg_mod_reg, 1'b0};
        priority if (!step_d2[MOD_WIDTH+2]) begin
            step_out = step_d2[MOD_WIDTH-1:0];
        end else if (!step_d1[MOD_WIDTH+2]) begin
            step_out = step_d1[MOD_WIDTH-1:0];
        end else begin
            step_out = step_sum[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mod_reg   <= MOD_WIDTH'(rme_pkg::MODULUS_RST);
            cfg_pub_reg   <= rme_pkg::PUB_EXP_RST;
            cfg_priv_reg  <= rme_pkg::PRIV_EXP_RST;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    rme_pkg::CFG_MODULUS:  cfg_mod_reg  <= cfg_wdata[MOD_WIDTH-1:0];
                    rme_pkg::CFG_PUB_EXP:  cfg_pub_reg  <= cfg_wdata;
                    rme_pkg::CFG_PRIV_EXP: cfg_priv_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.res_wr) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            val_reg  <= s_value;
            exp_reg  <= s_op ? cfg_priv_reg : cfg_pub_reg;
            base_reg <= '0;
            acc_reg  <= MOD_WIDTH'(1);
        end
        if (cmd.load || cmd.mul_load) begin
            cnt_reg <= '0;
        end else if (cmd.red_step || cmd.mul_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.red_step) begin
            base_reg <= step_out;
            val_reg  <= {val_reg[rme_pkg::VALUE_W-2:0], 1'b0};
        end
        if (cmd.mul_load) begin
            mul_a_reg <= base_reg;
            mul_b_reg <= cmd.mul_sq ? base_reg : acc_reg;
            prod_reg  <= '0;
        end
        if (cmd.mul_step) begin
            prod_reg  <= step_out;
            mul_b_reg <= {mul_b_reg[MOD_WIDTH-2:0], 1'b0};
        end
        if (cmd.acc_wr) begin
            acc_reg <= prod_reg;
        end
        if (cmd.base_wr) begin
            base_reg <= prod_reg;
        end
        if (cmd.exp_shift) begin
            exp_reg <= {1'b0, exp_reg[rme_pkg::CFG_W-1:1]};
        end
        if (cmd.res_wr) begin
            priority if (status.degenerate) begin
                res_reg <= '0;
            end else if (op_reg) begin
                res_reg <= {{(rme_pkg::RESULT_W-8){1'b0}}, acc_reg[7:0]};
            end else begin
                res_reg <= rme_pkg::RESULT_W'(acc_reg);
            end
        end
    end

    always_comb begin
        status.degenerate = (cfg_mod_reg[MOD_WIDTH-1:1] == '0);
        status.exp_zero   = (exp_reg == '0);
        status.exp_lsb    = exp_reg[0];
        status.red_last   = (cnt_reg == rme_pkg::VALUE_LAST);
        status.mul_last   = (cnt_reg == MUL_LAST);
        status.out_full   = res_valid_reg;
    end

    assign m_valid  = res_valid_reg;
    assign m_result = res_reg;

endmodule

`default_nettype wire

/* design/rsa_modexp_char_cipher.sv */
// Textbook RSA modular exponentiation, one word at a time.
// Configuration: write modulus (index 0), public exponent (1) and private
// exponent (2) through cfg_we/cfg_addr/cfg_wdata while no word is in flight.
// Input channel s_*: s_op selects encrypt (0, public exponent) or decrypt
// (1, private exponent); s_value is the base. Output channel m_*: m_result
// is s_value ** exponent mod modulus, cut to its low byte for decrypt.
// Throughput: one word at a time. A result is written after the value is
// reduced and, for each exponent bit up to the top set bit, the base is
// squared, with a multiply into the accumulator first for each set bit; the
// next word can be taken in the cycle after the result is written. This is
// set by the single bit-serial modular multiplier (one multiplier bit per
// cycle) and the bit-serial reduction of the value. A modulus below 2 gives
// 0 with no reduction or exponentiation.
// Reset restores modulus 3233, public exponent 7, private exponent 1783 and
// empties the output register. A finished word sits in the output register;
// the next word is accepted and computed while it waits, and its result is
// held back until the receiver takes the first one.
`default_nettype none

module rsa_modexp_char_cipher #(
    parameter int MOD_WIDTH = 32
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire  [rme_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [rme_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_op,
    input  wire  [rme_pkg::VALUE_W-1:0]     s_value,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [rme_pkg::RESULT_W-1:0]    m_result
);

    rme_pkg::rme_cmd_t    cmd;
    rme_pkg::rme_status_t status;

    // sequencer: load, reduce, then per exponent bit multiply if the bit is set, and square
    rme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // registers, shared doubling/add/reduce step and output register
    rme_dpath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_op      (s_op),
        .s_value   (s_value),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_result  (m_result)
    );

endmodule

`default_nettype wire

/* verif/rsa_modexp_char_cipher_test.sv */
`default_nettype none

module rsa_modexp_char_cipher_test;

    localparam int MOD_WIDTH = 32;

    // op codes on s_op
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // index past the register list; the block must drop writes to it
    localparam logic [rme_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 35;
    localparam int HOLD_CYCLES     = 5000;
    localparam int END_QUIET       = 2500;
    localparam int CYCLE_LIMIT     = 4_000_000;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

    // one row of the directed table: a word to send or a register to write
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  sel;           // op for a word, register index for a write
        logic [31:0] data;          // value for a word, data for a write
        bit          known;         // result typed in below
        logic [31:0] known_result;
    } stim_row_t;

    typedef struct {
        logic        op;
        logic [31:0] value;
        logic [31:0] result;
    } cipher_word_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [rme_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [rme_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    wire                            s_ready;
    logic                           s_op      = 1'b0;
    logic [rme_pkg::VALUE_W-1:0]    s_value   = '0;
    wire                            m_valid;
    logic                           m_ready   = 1'b0;
    wire  [rme_pkg::RESULT_W-1:0]   m_result;

    // travels with the payload: a typed-in result for directed rows
    bit          s_known        = 1'b0;
    logic [31:0] s_known_result = '0;

    // key registers as the block should hold them
    logic [31:0] key_modulus = rme_pkg::MODULUS_RST;
    logic [31:0] key_public  = rme_pkg::PUB_EXP_RST;
    logic [31:0] key_private = rme_pkg::PRIV_EXP_RST;

    cipher_word_t pending_results[$];
    stim_row_t    directed_rows[$];

    int send_pct = 0;   // chance per cycle that the sender sits idle
    int recv_pct = 0;   // chance per cycle that the receiver stalls
    bit hold_req = 1'b0;

    int error_count     = 0;
    int words_taken     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    rsa_modexp_char_cipher #(
        .MOD_WIDTH (MOD_WIDTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Right-to-left square and multiply on 64-bit products, then cut to a
    // byte for decrypt. A modulus below 2 yields 0 with no reduction at all.
    function automatic logic [31:0] cipher_result(logic op, logic [31:0] value);
        logic [63:0] m;
        logic [63:0] base;
        logic [63:0] acc;
        logic [31:0] expo;
        m = {32'd0, key_modulus} & ((64'd1 << MOD_WIDTH) - 64'd1);
        if (m < 64'd2)
            return 32'd0;
        acc  = 64'd1;
        base = {32'd0, value} % m;
        expo = (op == OP_DECRYPT) ? key_private : key_public;
        while (expo != 32'd0) begin
            if (expo[0])
                acc = (acc * base) % m;
            expo = expo >> 1;
            base = (base * base) % m;
        end
        if (op == OP_DECRYPT)
            acc = acc & 64'hFF;
        return acc[31:0];
    endfunction

    // exponent of random bit length 0..12, top bit set so the length holds
    function automatic logic [31:0] short_exponent();
        int len;
        len = $urandom_range(0, 12);
        if (len == 0)
            return 32'd0;
        return ($urandom & ((32'd1 << len) - 32'd1)) | (32'd1 << (len - 1));
    endfunction

    // mix of full-range, in-range and boundary values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3:       return (key_modulus > 32'd1) ? ($urandom % key_modulus) : $urandom;
            4:       return $urandom_range(0, 255);
            5:       return $urandom_range(0, 1);
            6:       return key_modulus - $urandom_range(0, 1);
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void add_word(logic op, logic [31:0] value, bit known,
                                     logic [31:0] res);
        stim_row_t row;
        row.kind = ROW_WORD;
        row.sel = {1'b0, op};
        row.data = value;
        row.known = known;
        row.known_result = res;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_reg(logic [rme_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] data);
        stim_row_t row;
        row.kind = ROW_REG;
        row.sel = idx;
        row.data = data;
        row.known = 1'b0;
        row.known_result = '0;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Offer one word; entered and left at a falling edge. A previous word
    // may still sit on the bus, already taken: replace it or drop valid.
    task automatic send_word(input logic op, input logic [31:0] value,
                             input bit known, input logic [31:0] res);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_value        <= value;
        s_known        <= known;
        s_known_result <= res;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding result is back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // One register write; only called with nothing in flight.
    task automatic write_reg(input logic [rme_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rme_pkg::CFG_MODULUS:  key_modulus = data;
            rme_pkg::CFG_PUB_EXP:  key_public  = data;
            rme_pkg::CFG_PRIV_EXP: key_private = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
    endtask

    // Watch both handshakes at the rising edge: predict on input accept,
    // compare on output accept.
    always @(posedge aclk) begin : port_watch
        cipher_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want.op     = s_op;
                want.value  = s_value;
                want.result = s_known ? s_known_result : cipher_result(s_op, s_value);
                pending_results = {pending_results, want};
                words_taken++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result %h with no word outstanding", m_result));
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (m_result !== want.result)
                        flag_mismatch($sformatf("op %0d value %h: result %h, want %h",
                                                want.op, want.value, m_result, want.result));
                end
            end
        end
    end

    // Receiver: random stalls per cycle, or one long hold-off on request so
    // the block backs up into its input.
    initial begin : result_taker
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("rsa_modexp_char_cipher test failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] m;
        logic [31:0] e;
        logic [31:0] d;
        stim_row_t   row;

        // Directed table. Reset keys first: n 3233, e 7, d 1783.
        add_word(OP_ENCRYPT, 32'd0,           1'b1, 32'd0);
        add_word(OP_ENCRYPT, 32'd1,           1'b1, 32'd1);
        add_word(OP_DECRYPT, 32'd0,           1'b1, 32'd0);
        add_word(OP_DECRYPT, 32'd1,           1'b1, 32'd1);
        add_word(OP_ENCRYPT, 32'd3233,        1'b1, 32'd0);   // value equal to modulus
        add_word(OP_ENCRYPT, 32'd65,          1'b0, 32'd0);
        add_word(OP_ENCRYPT, 32'd255,         1'b0, 32'd0);
        add_word(OP_DECRYPT, 32'd255,         1'b0, 32'd0);
        add_word(OP_ENCRYPT, 32'hFFFF_FFFF,   1'b0, 32'd0);   // reduce before power
        add_word(OP_DECRYPT, 32'hFFFF_FFFF,   1'b0, 32'd0);
        // write past the register list: keys must stay as they were
        add_reg(CFG_UNUSED, 32'd0);
        add_word(OP_ENCRYPT, 32'd2,           1'b0, 32'd0);
        // degenerate moduli give 0 for everything
        add_reg(rme_pkg::CFG_MODULUS, 32'd1);
        add_word(OP_ENCRYPT, 32'd5,           1'b1, 32'd0);
        add_word(OP_DECRYPT, 32'd5,           1'b1, 32'd0);
        add_reg(rme_pkg::CFG_MODULUS, 32'd0);
        add_word(OP_ENCRYPT, 32'hFFFF_FFFF,   1'b1, 32'd0);
        add_word(OP_DECRYPT, 32'd7,           1'b1, 32'd0);
        // zero exponents give 1, even for a zero base
        add_reg(rme_pkg::CFG_MODULUS,  32'hFFFF_FFFF);
        add_reg(rme_pkg::CFG_PUB_EXP,  32'd0);
        add_reg(rme_pkg::CFG_PRIV_EXP, 32'd0);
        add_word(OP_ENCRYPT, 32'd123,         1'b1, 32'd1);
        add_word(OP_DECRYPT, 32'hFFFF_FFFF,   1'b1, 32'd1);
        add_word(OP_ENCRYPT, 32'd0,           1'b1, 32'd1);
        // smallest modulus with all-ones exponents: parity of the base
        add_reg(rme_pkg::CFG_MODULUS,  32'd2);
        add_reg(rme_pkg::CFG_PUB_EXP,  32'hFFFF_FFFF);
        add_reg(rme_pkg::CFG_PRIV_EXP, 32'hFFFF_FFFF);
        add_word(OP_ENCRYPT, 32'd3,           1'b1, 32'd1);
        add_word(OP_DECRYPT, 32'd2,           1'b1, 32'd0);
        add_word(OP_ENCRYPT, 32'hFFFF_FFFF,   1'b1, 32'd1);
        // largest modulus: minus one to an odd power stays minus one
        add_reg(rme_pkg::CFG_MODULUS,  32'hFFFF_FFFF);
        add_word(OP_ENCRYPT, 32'hFFFF_FFFE,   1'b1, 32'hFFFF_FFFE);
        add_word(OP_DECRYPT, 32'hFFFF_FFFE,   1'b1, 32'h0000_00FE);

        // hold reset, then release it at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_reg(row.sel, row.data);
            end else begin
                send_word(row.sel[0], row.data, row.known, row.known_result);
            end
        end

        // Random phases: each writes all three keys while idle, then runs
        // under one idling pattern, cycling through all four.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    m = rme_pkg::MODULUS_RST;
                    e = rme_pkg::PUB_EXP_RST;
                    d = rme_pkg::PRIV_EXP_RST;
                end
                1: begin
                    m = $urandom_range(256, 65535);
                    e = short_exponent();
                    d = short_exponent();
                end
                2: begin
                    m = $urandom | 32'h8000_0001;
                    e = short_exponent();
                    d = short_exponent();
                end
                3: begin
                    m = $urandom_range(2, 300);
                    e = short_exponent();
                    d = short_exponent();
                end
                4: begin
                    m = 32'hFFFF_FFFF;
                    e = $urandom;
                    d = $urandom;
                end
                5: begin
                    m = $urandom;
                    e = $urandom | 32'h8000_0000;
                    d = $urandom;
                end
                6: begin
                    m = $urandom_range(0, 1);
                    e = short_exponent();
                    d = short_exponent();
                end
                default: begin
                    m = $urandom;
                    e = 32'd0;
                    d = short_exponent();
                end
            endcase
            write_reg(rme_pkg::CFG_MODULUS,  m);
            write_reg(rme_pkg::CFG_PUB_EXP,  e);
            write_reg(rme_pkg::CFG_PRIV_EXP, d);

            case (phase % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 46; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 46; end
                default: begin send_pct = 18; recv_pct = 18; end
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // stall the receiver for a long stretch while words keep coming
                if (phase == 2 && n == 4)
                    hold_req = 1'b1;
                // let the block run dry mid-phase
                if (phase == 3 && n == WORDS_PER_PHASE / 2)
                    drain_results();
                send_word(1'($urandom_range(0, 1)), pick_value(), 1'b0, 32'd0);
            end
        end

        // drain, then watch a while for anything stray
        drain_results();
        repeat (END_QUIET) @(negedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d words, %0d results checked, %0d register writes in %0d cycles",
                 words_taken, results_checked, reg_writes, cycle_count);
        $display("key sets: reset, small, full-width and degenerate moduli, zero to 32-bit exponents");
        if (error_count == 0)
            $display("rsa_modexp_char_cipher test passed");
        else
            $display("rsa_modexp_char_cipher test failed");
        $finish;
    end

endmodule

`default_nettype wire
